// ----- hdl/vpup_pkg.sv -----
// shared types and codes for the vif packet unpack parser
// no dependencies
package vpup_pkg;

  localparam logic [3:0] KIND_CLOSE    = 4'd0;
  localparam logic [3:0] KIND_POSITION = 4'd1;
  localparam logic [3:0] KIND_LOCATION = 4'd2;
  localparam logic [3:0] KIND_TEXCOORD = 4'd3;
  localparam logic [3:0] KIND_NORMAL   = 4'd4;
  localparam logic [3:0] KIND_GIF      = 4'd5;
  localparam logic [3:0] KIND_DIRECT   = 4'd6;
  localparam logic [3:0] KIND_XLOC     = 4'd7;
  localparam logic [3:0] KIND_WEIGHT   = 4'd8;
  localparam logic [3:0] KIND_NOTICE   = 4'd9;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_MCODE = 3'd1;
  localparam logic [2:0] ST_ODD_GIF   = 3'd2;
  localparam logic [2:0] ST_SIGNED_V4 = 3'd3;
  localparam logic [2:0] ST_BAD_UNPK  = 3'd4;
  localparam logic [2:0] ST_BAD_CMD   = 3'd5;

  localparam logic [6:0] CMD_NOP0   = 7'h00;
  localparam logic [6:0] CMD_NOP1   = 7'h01;
  localparam logic [6:0] CMD_NOP4   = 7'h04;
  localparam logic [6:0] CMD_NOP5   = 7'h05;
  localparam logic [6:0] CMD_NOP11  = 7'h11;
  localparam logic [6:0] CMD_MSCAL  = 7'h14;
  localparam logic [6:0] CMD_STMASK = 7'h20;
  localparam logic [6:0] CMD_DIRECT = 7'h50;

  localparam int unsigned QDepth = 2;

  typedef struct packed {
    logic [3:0]         kind;
    logic [2:0]         status;
    logic signed [16:0] comp_a;
    logic signed [16:0] comp_b;
    logic signed [16:0] comp_c;
    logic [15:0]        comp_d;
    logic [31:0]        bone_set;
    logic [31:0]        weight_set;
    logic [63:0]        wide_word;
    logic [16:0]        word_index;
  } rec_t;

endpackage

// ----- hdl/vpup_front.sv -----
// front end: assembles headers and payload elements, classifies commands
// depends on vpup_pkg
module vpup_front import vpup_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  logic [7:0]  byte_i,
  input  logic        last_i,
  output logic        push_o,
  output rec_t        rec_o
);

  typedef enum logic [3:0] {
    PH_HEADER, PH_SKIP, PH_UV, PH_V3_16, PH_V3_8,
    PH_GIF, PH_DIRECT, PH_XLOC, PH_WEIGHT
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [31:0] hw_q, hw_d;
  logic [1:0]  hcnt_q, hcnt_d;
  logic [20:0] left_q, left_d;
  logic [63:0] ebuf_q, ebuf_d;
  logic [3:0]  ecnt_q, ecnt_d;
  logic [16:0] elems_q, elems_d;
  logic [16:0] wvc_q, wvc_d;
  logic        closed_q, closed_d;
  logic        disc_q, disc_d;

  function automatic logic [16:0] sx16(input logic [15:0] v);
    return {v[15], v};
  endfunction
  function automatic logic [16:0] sx8(input logic [7:0] v);
    return {{9{v[7]}}, v};
  endfunction

  always_comb begin
    logic [15:0] imm;
    logic [7:0]  num;
    logic [6:0]  cmd;
    logic [63:0] b;
    logic [3:0]  n;
    logic        emit;
    logic [31:0] g, h;
    logic        second, need;
    logic [7:0]  bone2, w2, bone3, w3, bone4, w4;
    logic [16:0] total;
    phase_d  = phase_q;
    hw_d     = hw_q;
    hcnt_d   = hcnt_q;
    left_d   = left_q;
    ebuf_d   = ebuf_q;
    ecnt_d   = ecnt_q;
    elems_d  = elems_q;
    wvc_d    = wvc_q;
    closed_d = closed_q;
    disc_d   = disc_q;
    push_o   = 1'b0;
    rec_o    = '0;
    imm = '0; num = '0; cmd = '0; b = '0; n = '0; emit = 1'b0;
    g = '0; h = '0; second = 1'b0; need = 1'b0;
    bone2 = '0; w2 = '0; bone3 = 8'hFF; w3 = '0; bone4 = 8'hFF; w4 = '0;
    total = '0;
    if (take_i && !disc_q) begin
      if (phase_q == PH_HEADER) begin
        hw_d = (hcnt_q == 2'd0) ? 32'd0 : hw_q;
        hw_d[hcnt_q*8 +: 8] = byte_i;
        hcnt_d = hcnt_q + 2'd1;
        if (hcnt_q == 2'd3) begin
          imm = hw_d[15:0];
          num = hw_d[23:16];
          cmd = hw_d[30:24];
          ebuf_d = '0;
          ecnt_d = '0;
          unique case (cmd)
            CMD_NOP0, CMD_NOP1, CMD_NOP4, CMD_NOP5, CMD_NOP11: ;
            CMD_MSCAL: begin
              push_o = 1'b1;
              rec_o.kind = KIND_CLOSE;
              rec_o.status = (imm == 16'd66 || imm == 16'd68 || imm == 16'd70)
                             ? ST_OK : ST_BAD_MCODE;
              rec_o.comp_a = {1'b0, imm};
              closed_d = 1'b1;
            end
            CMD_STMASK: begin
              phase_d = PH_SKIP; left_d = 21'd4; elems_d = '0;
            end
            CMD_DIRECT: begin
              left_d  = {1'b0, imm, 4'd0};
              elems_d = {imm, 1'b0};
              phase_d = PH_DIRECT;
            end
            default: begin
              if (cmd[6:5] != 2'b11) begin
                disc_d = 1'b1;
                push_o = 1'b1;
                rec_o.kind = KIND_NOTICE;
                rec_o.status = ST_BAD_CMD;
              end else begin
                unique case (cmd[3:0])
                  4'b0101: begin
                    left_d = {11'd0, num, 2'd0};
                    elems_d = closed_q ? {9'd0, num} : 17'd0;
                    phase_d = closed_q ? PH_UV : PH_SKIP;
                  end
                  4'b1001: begin
                    left_d = 21'(({13'd0, num} * 21'd6 + 21'd3) & ~21'd3);
                    elems_d = {9'd0, num};
                    phase_d = PH_V3_16;
                  end
                  4'b1010: begin
                    left_d = 21'(({13'd0, num} * 21'd3 + 21'd3) & ~21'd3);
                    elems_d = {9'd0, num};
                    phase_d = PH_V3_8;
                  end
                  4'b1100: begin
                    left_d = {9'd0, num, 4'd0};
                    if (num == 8'd1 || num == 8'd2) begin
                      elems_d = {8'd0, num, 1'b0};
                      phase_d = PH_GIF;
                    end else begin
                      elems_d = '0;
                      phase_d = PH_SKIP;
                      push_o = 1'b1;
                      rec_o.kind = KIND_NOTICE;
                      rec_o.status = ST_ODD_GIF;
                    end
                  end
                  4'b1101: begin
                    left_d = {10'd0, num, 3'd0};
                    if (imm[14]) begin
                      elems_d = {9'd0, num};
                      phase_d = PH_XLOC;
                    end else begin
                      elems_d = '0;
                      phase_d = PH_SKIP;
                      push_o = 1'b1;
                      rec_o.kind = KIND_NOTICE;
                      rec_o.status = ST_SIGNED_V4;
                    end
                  end
                  4'b1110: begin
                    wvc_d = '0;
                    left_d = {11'd0, num, 2'd0};
                    elems_d = {9'd0, num};
                    phase_d = PH_WEIGHT;
                  end
                  default: begin
                    disc_d = 1'b1;
                    push_o = 1'b1;
                    rec_o.kind = KIND_NOTICE;
                    rec_o.status = ST_BAD_UNPK;
                  end
                endcase
              end
            end
          endcase
          // zero-length payload stays in header phase
          if (left_d == '0) phase_d = PH_HEADER;
        end
      end else begin
        if (left_q != '0) left_d = left_q - 21'd1;
        if (phase_q != PH_SKIP && elems_q != '0 && !ecnt_q[3]) begin
          b = ebuf_q;
          b[ecnt_q[2:0]*8 +: 8] = byte_i;
          n = ecnt_q + 4'd1;
          ebuf_d = b;
          ecnt_d = n;
          case (phase_q)
            PH_UV: if (n == 4'd4) begin
              emit = 1'b1;
              rec_o.kind = KIND_TEXCOORD;
              rec_o.comp_a = sx16(b[15:0]);
              rec_o.comp_b = sx16(b[31:16]);
            end
            PH_V3_16: if (n == 4'd6) begin
              emit = 1'b1;
              if (hw_q[14]) begin
                rec_o.kind = KIND_LOCATION;
                rec_o.comp_a = {1'b0, b[15:0]};
                rec_o.comp_b = {1'b0, b[31:16]};
                rec_o.comp_c = {1'b0, b[47:32]};
              end else begin
                rec_o.kind = KIND_POSITION;
                rec_o.comp_a = sx16(b[15:0]);
                rec_o.comp_b = sx16(b[31:16]);
                rec_o.comp_c = sx16(b[47:32]);
              end
            end
            PH_V3_8: if (n == 4'd3) begin
              emit = 1'b1;
              rec_o.kind = KIND_NORMAL;
              rec_o.comp_a = sx8(b[7:0]);
              rec_o.comp_b = sx8(b[15:8]);
              rec_o.comp_c = sx8(b[23:16]);
            end
            PH_GIF, PH_DIRECT: if (n == 4'd8) begin
              emit = 1'b1;
              total = (phase_q == PH_GIF) ? {8'd0, hw_q[23:16], 1'b0}
                                          : {hw_q[15:0], 1'b0};
              rec_o.kind = (phase_q == PH_GIF) ? KIND_GIF : KIND_DIRECT;
              rec_o.wide_word = b;
              rec_o.word_index = total - elems_q;
            end
            PH_XLOC: if (n == 4'd8) begin
              emit = 1'b1;
              rec_o.kind = KIND_XLOC;
              rec_o.comp_a = {1'b0, b[15:0]};
              rec_o.comp_b = {1'b0, b[31:16]};
              rec_o.comp_c = {1'b0, b[47:32]};
              rec_o.comp_d = b[63:48];
            end
            PH_WEIGHT: begin
              g = b[31:0];
              h = b[63:32];
              need = g[23:16] != 8'hFF &&
                     ({1'b0, g[15:8]} + {1'b0, g[31:24]}) < 9'h0FF &&
                     elems_q >= 17'd2;
              if (n == 4'd4 && !need) emit = 1'b1;
              if (n == 4'd8) begin
                emit = 1'b1;
                second = 1'b1;
              end
              if (emit) begin
                if (g[23:16] == 8'hFF) begin
                  bone2 = 8'hFF;
                  wvc_d = wvc_q + {9'd0, g[31:24]};
                end else begin
                  bone2 = {2'd0, g[23:18]};
                  w2 = g[31:24];
                  wvc_d = wvc_q + 17'd1;
                  if (second) begin
                    bone3 = {2'd0, h[7:2]};
                    w3 = h[15:8];
                    if (h[23:16] != 8'hFF) begin
                      bone4 = {2'd0, h[23:18]};
                      w4 = h[31:24];
                    end
                  end
                end
                rec_o.kind = KIND_WEIGHT;
                rec_o.comp_a = wvc_q;
                rec_o.comp_b = wvc_d - 17'd1;
                rec_o.bone_set = {bone4, bone3, bone2, 2'd0, g[7:2]};
                rec_o.weight_set = {w4, w3, w2, g[15:8]};
              end
            end
            default: ;
          endcase
          if (emit) begin
            push_o = 1'b1;
            elems_d = elems_q - (second ? 17'd2 : 17'd1);
            ebuf_d = '0;
            ecnt_d = '0;
          end
        end
        if (left_d == '0) begin
          phase_d = PH_HEADER;
          ebuf_d = '0;
          ecnt_d = '0;
          elems_d = '0;
        end
      end
    end
    if (take_i && last_i) begin
      phase_d = PH_HEADER; hw_d = '0; hcnt_d = '0; left_d = '0; ebuf_d = '0;
      ecnt_d = '0; elems_d = '0; wvc_d = '0; closed_d = 1'b0; disc_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER; hw_q <= '0; hcnt_q <= '0; left_q <= '0;
      ebuf_q <= '0; ecnt_q <= '0; elems_q <= '0; wvc_q <= '0;
      closed_q <= 1'b0; disc_q <= 1'b0;
    end else begin
      phase_q <= phase_d; hw_q <= hw_d; hcnt_q <= hcnt_d; left_q <= left_d;
      ebuf_q <= ebuf_d; ecnt_q <= ecnt_d; elems_q <= elems_d; wvc_q <= wvc_d;
      closed_q <= closed_d; disc_q <= disc_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ecnt_q <= 4'd8) else $error("element byte count overrun");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_HEADER) |-> (left_q != '0)) else $error("payload phase with no bytes");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    disc_q |-> (phase_q == PH_HEADER)) else $error("discard outside header phase");

endmodule

// ----- hdl/vpup_queue.sv -----
// back end: two-entry record queue feeding the output stream
// depends on vpup_pkg
module vpup_queue import vpup_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rec_t rec_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output rec_t rec_o
);

  rec_t       mem_q [QDepth];
  logic       rd_q, wr_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign pop     = pop_i && (cnt_q != 2'd0);
  assign valid_o = cnt_q != 2'd0;
  assign full_o  = cnt_q == 2'(QDepth);
  assign rec_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0; wr_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(QDepth)) else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !pop_i) |=> full_o) else $error("full queue lost an entry");

endmodule

// ----- hdl/vif_packet_unpack_parser.sv -----
// top level of the vif packet unpack parser: byte front end and record queue
// depends on vpup_pkg, vpup_front and vpup_queue
// latency: a record is offered the cycle after its last byte into an empty queue
// throughput: one byte per cycle, set by the front end's single-byte step
// a byte is refused only while both queue entries hold untaken records
// reset: asynchronous active low, parser to header phase, queue emptied
module vif_packet_unpack_parser import vpup_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // data_byte
  input  logic         s_axis_tlast_i,   // region_end
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // status[2:0] comp_a[19:3] comp_b[36:20] comp_c[53:37] comp_d[69:54]
  // bone_set[101:70] weight_set[133:102] wide_word[197:134] word_index[214:198]
  output logic [215:0] m_axis_tdata_o,
  output logic [3:0]   m_axis_tuser_o    // record_kind
);

  logic take, push, full;
  rec_t rec_front, rec_back;

  // any byte may yield a record, so take bytes only with a free queue entry
  assign s_axis_tready_o = !full;
  assign take = s_axis_tvalid_i && s_axis_tready_o;

  vpup_front u_front (
    .clk_i, .rst_ni,
    .take_i (take),
    .byte_i (s_axis_tdata_i),
    .last_i (s_axis_tlast_i),
    .push_o (push),
    .rec_o  (rec_front)
  );

  vpup_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .rec_i   (rec_front),
    .full_o  (full),
    .valid_o (m_axis_tvalid_o),
    .pop_i   (m_axis_tready_i),
    .rec_o   (rec_back)
  );

  // pack the record fields, lowest first
  assign m_axis_tuser_o = rec_back.kind;
  assign m_axis_tdata_o = {1'b0, rec_back.word_index, rec_back.wide_word,
                           rec_back.weight_set, rec_back.bone_set,
                           rec_back.comp_d, rec_back.comp_c, rec_back.comp_b,
                           rec_back.comp_a, rec_back.status};

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for vif_packet_unpack_parser: byte stream in, records out
// depends on vpup_pkg and the block's rtl
`timescale 1ns / 100ps

module tb_top;
  import vpup_pkg::*;

  localparam int PH_HEADER = 0, PH_SKIP = 1, PH_UV = 2, PH_V3_16 = 3, PH_V3_8 = 4,
                 PH_GIF = 5, PH_DIRECT = 6, PH_XLOC = 7, PH_WEIGHT = 8;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [7:0]   s_axis_tdata_i = '0;   // data_byte
  logic         s_axis_tlast_i = 1'b0; // region_end
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [215:0] m_axis_tdata_o;        // status, comp_a..d, bones, weights, word, index
  logic [3:0]   m_axis_tuser_o;        // record_kind

  vif_packet_unpack_parser DUT (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // parser copy kept by the testbench
  int          phase;
  logic [31:0] hdr;
  int          hcnt;
  int unsigned bytes_left;
  logic [63:0] ebuf;
  int          ecnt;
  int unsigned elems_left;
  logic [16:0] vcount;
  bit          closed_seen;
  bit          discarding;

  rec_t expected_recs[$];
  int   mismatches = 0;
  int   send_idle_pct = 15;
  int   recv_idle_pct = 69;
  int   bytes_total = 0;

  function automatic void parser_clear();
    phase = PH_HEADER; hdr = '0; hcnt = 0; bytes_left = 0; ebuf = '0; ecnt = 0;
    elems_left = 0; vcount = '0; closed_seen = 0; discarding = 0;
  endfunction

  function automatic logic [16:0] sext16(logic [15:0] v);
    return {v[15], v};
  endfunction

  function automatic logic [16:0] sext8(logic [7:0] v);
    return {{9{v[7]}}, v};
  endfunction

  function automatic void begin_payload(int ph, int unsigned nbytes, int unsigned nelem);
    ebuf = '0; ecnt = 0; elems_left = nelem; bytes_left = nbytes;
    phase = (nbytes != 0) ? ph : PH_HEADER;
  endfunction

  function automatic bit decode_cmd(ref rec_t r);
    logic [15:0] imm;
    logic [7:0]  num;
    logic [6:0]  cmd;
    int          vn, vl;
    imm = hdr[15:0]; num = hdr[23:16]; cmd = hdr[30:24];
    case (cmd)
      CMD_NOP0, CMD_NOP1, CMD_NOP4, CMD_NOP5, CMD_NOP11: return 0;
      CMD_MSCAL: begin
        r.kind = KIND_CLOSE;
        r.status = (imm == 66 || imm == 68 || imm == 70) ? ST_OK : ST_BAD_MCODE;
        r.comp_a = {1'b0, imm};
        closed_seen = 1;
        return 1;
      end
      CMD_STMASK: begin begin_payload(PH_SKIP, 4, 0); return 0; end
      CMD_DIRECT: begin begin_payload(PH_DIRECT, imm * 16, imm * 2); return 0; end
      default: ;
    endcase
    r.kind = KIND_NOTICE;
    if (cmd[6:5] != 2'b11) begin
      discarding = 1; r.status = ST_BAD_CMD; return 1;
    end
    vn = cmd[3:2]; vl = cmd[1:0];
    if (vn == 1 && vl == 1) begin
      if (closed_seen) begin_payload(PH_UV, num * 4, num);
      else begin_payload(PH_SKIP, num * 4, 0);
    end else if (vn == 2 && vl == 1) begin
      begin_payload(PH_V3_16, (num * 6 + 3) & ~3, num);
    end else if (vn == 2 && vl == 2) begin
      begin_payload(PH_V3_8, (num * 3 + 3) & ~3, num);
    end else if (vn == 3 && vl == 0) begin
      if (num == 1 || num == 2) begin
        begin_payload(PH_GIF, num * 16, num * 2);
      end else begin
        begin_payload(PH_SKIP, num * 16, 0); r.status = ST_ODD_GIF; return 1;
      end
    end else if (vn == 3 && vl == 1) begin
      if (imm[14]) begin
        begin_payload(PH_XLOC, num * 8, num);
      end else begin
        begin_payload(PH_SKIP, num * 8, 0); r.status = ST_SIGNED_V4; return 1;
      end
    end else if (vn == 3 && vl == 2) begin
      vcount = '0;
      begin_payload(PH_WEIGHT, num * 4, num);
    end else begin
      discarding = 1; r.status = ST_BAD_UNPK; return 1;
    end
    return 0;
  endfunction

  // one skin-weight group, with the optional continuation group h
  function automatic void weight_rec(ref rec_t r, input logic [31:0] g, logic [31:0] h,
                                     input bit second);
    logic [16:0] first_v;
    logic [7:0]  bn2, wt2, bn3, wt3, bn4, wt4;
    first_v = vcount;
    bn3 = 8'hFF; wt3 = 0; bn4 = 8'hFF; wt4 = 0;
    if (g[23:16] == 8'hFF) begin
      bn2 = 8'hFF; wt2 = 0; vcount = vcount + g[31:24];
    end else begin
      bn2 = g[23:16] >> 2; wt2 = g[31:24]; vcount = vcount + 1;
      if (second) begin
        bn3 = h[7:0] >> 2; wt3 = h[15:8];
        if (h[23:16] != 8'hFF) begin
          bn4 = h[23:16] >> 2; wt4 = h[31:24];
        end
      end
    end
    r.kind = KIND_WEIGHT;
    r.comp_a = first_v;
    r.comp_b = vcount - 17'd1;
    r.bone_set = {bn4, bn3, bn2, g[7:0] >> 2};
    r.weight_set = {wt4, wt3, wt2, g[15:8]};
  endfunction

  function automatic bit element_complete(ref rec_t r);
    int unsigned total;
    bit          need;
    case (phase)
      PH_UV: begin
        if (ecnt != 4) return 0;
        r.kind = KIND_TEXCOORD; r.comp_a = sext16(ebuf[15:0]); r.comp_b = sext16(ebuf[31:16]);
      end
      PH_V3_16: begin
        if (ecnt != 6) return 0;
        if (hdr[14]) begin
          r.kind = KIND_LOCATION; r.comp_a = {1'b0, ebuf[15:0]};
          r.comp_b = {1'b0, ebuf[31:16]}; r.comp_c = {1'b0, ebuf[47:32]};
        end else begin
          r.kind = KIND_POSITION; r.comp_a = sext16(ebuf[15:0]);
          r.comp_b = sext16(ebuf[31:16]); r.comp_c = sext16(ebuf[47:32]);
        end
      end
      PH_V3_8: begin
        if (ecnt != 3) return 0;
        r.kind = KIND_NORMAL; r.comp_a = sext8(ebuf[7:0]);
        r.comp_b = sext8(ebuf[15:8]); r.comp_c = sext8(ebuf[23:16]);
      end
      PH_GIF, PH_DIRECT: begin
        if (ecnt != 8) return 0;
        total = (phase == PH_GIF) ? hdr[23:16] * 2 : hdr[15:0] * 2;
        r.kind = (phase == PH_GIF) ? KIND_GIF : KIND_DIRECT;
        r.wide_word = ebuf;
        r.word_index = 17'(total - elems_left);
      end
      PH_XLOC: begin
        if (ecnt != 8) return 0;
        r.kind = KIND_XLOC; r.comp_a = {1'b0, ebuf[15:0]}; r.comp_b = {1'b0, ebuf[31:16]};
        r.comp_c = {1'b0, ebuf[47:32]}; r.comp_d = ebuf[63:48];
      end
      PH_WEIGHT: begin
        if (ecnt == 4) begin
          need = ebuf[23:16] != 8'hFF && (int'(ebuf[15:8]) + int'(ebuf[31:24])) < 255
                 && elems_left >= 2;
          if (need) return 0;
          weight_rec(r, ebuf[31:0], '0, 0);
        end else if (ecnt == 8) begin
          weight_rec(r, ebuf[31:0], ebuf[63:32], 1);
          elems_left--;
        end else begin
          return 0;
        end
      end
      default: return 0;
    endcase
    elems_left--; ebuf = '0; ecnt = 0;
    return 1;
  endfunction

  // advance the parser copy by one byte; queue any record it makes
  function automatic void parse_byte(logic [7:0] b, logic last);
    rec_t r;
    bit   got;
    r = '0; got = 0;
    if (discarding) begin
    end else if (phase == PH_HEADER) begin
      if (hcnt == 0) hdr = '0;
      hdr = hdr | (32'(b) << (8 * hcnt));
      hcnt = (hcnt + 1) & 3;
      if (hcnt == 0) got = decode_cmd(r);
    end else begin
      if (bytes_left != 0) bytes_left--;
      if (phase != PH_SKIP && elems_left > 0 && ecnt < 8) begin
        ebuf = ebuf | (64'(b) << (8 * ecnt));
        ecnt++;
        got = element_complete(r);
      end
      if (bytes_left == 0) begin
        phase = PH_HEADER; ebuf = '0; ecnt = 0; elems_left = 0;
      end
    end
    if (last) parser_clear();
    if (got) expected_recs.insert(expected_recs.size(), r);
  endfunction

  // ---------------- stimulus ----------------
  task automatic send_byte(logic [7:0] b, bit last);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    parse_byte(b, last);
    bytes_total++;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
  endtask

  task automatic send_header(logic [6:0] cmd, logic [7:0] num, logic [15:0] imm, bit last = 0);
    send_byte(imm[7:0], 0);
    send_byte(imm[15:8], 0);
    send_byte(num, 0);
    send_byte({1'($urandom_range(1)), cmd}, last);
  endtask

  // a command with random content, sometimes malformed; weight groups biased to hit pairs
  task automatic random_command();
    int          pick, n, nbytes;
    logic [6:0]  cmd;
    logic [7:0]  num;
    logic [15:0] imm;
    logic [7:0]  b;
    pick = $urandom_range(11);
    num = 8'($urandom_range(4, 0));
    imm = 16'($urandom);
    case (pick)
      0: cmd = CMD_MSCAL;
      1: cmd = CMD_STMASK;
      2: begin cmd = CMD_DIRECT; imm = 16'($urandom_range(2)); end
      3: cmd = 7'h65;                   // texcoords
      4: cmd = 7'h69;                   // positions / locations
      5: cmd = 7'h6A;                   // normals
      6: begin cmd = 7'h6C; num = 8'($urandom_range(3)); end
      7: cmd = 7'h6D;                   // extra locations
      8, 9: cmd = 7'h6E;                // weights
      10: cmd = $urandom_range(1) ? CMD_NOP0 : CMD_NOP11;
      default: cmd = $urandom_range(1) ? 7'h6B : 7'h7F;
    endcase
    if (pick == 0 && $urandom_range(1)) imm = 16'(66 + 2 * $urandom_range(2));
    send_header(cmd, num, imm);
    if (discarding) return;
    nbytes = int'(bytes_left);
    for (n = 0; n < nbytes; n++) begin
      b = 8'($urandom);
      if (cmd == 7'h6E && n % 4 == 2 && $urandom_range(3) == 0) b = 8'hFF;
      if (cmd == 7'h6E && (n % 4 == 1 || n % 4 == 3) && $urandom_range(1)) b = b >> 2;
      send_byte(b, 0);
    end
  endtask

  task automatic random_region();
    int k, cmds;
    cmds = $urandom_range(6, 1);
    for (k = 0; k < cmds && !discarding; k++) random_command();
    // end the region; sometimes mid-command, sometimes after a noise byte run
    repeat ($urandom_range(3)) send_byte(8'($urandom), 0);
    send_byte(8'($urandom), 1);
  endtask

  typedef struct {
    logic [7:0] b;
    bit         last;
    bit         checked;   // typed-in expectation present
    rec_t       rec;
  } stim_row_t;

  stim_row_t dir_rows[$];

  function automatic void row(logic [7:0] b, bit last = 0);
    stim_row_t s;
    s.b = b; s.last = last; s.checked = 0; s.rec = '0;
    dir_rows.insert(dir_rows.size(), s);
  endfunction

  function automatic void row_exp(logic [7:0] b, logic [3:0] k, logic [2:0] st,
                                  logic [16:0] a);
    stim_row_t s;
    s.b = b; s.last = 0; s.checked = 1; s.rec = '0;
    s.rec.kind = k; s.rec.status = st; s.rec.comp_a = a;
    dir_rows.insert(dir_rows.size(), s);
  endfunction

  // ---------------- result checking ----------------
  always @(posedge clk_i) begin
    rec_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = '0;
      got.kind = m_axis_tuser_o;
      {got.word_index, got.wide_word, got.weight_set, got.bone_set, got.comp_d,
       got.comp_c, got.comp_b, got.comp_a, got.status} = m_axis_tdata_o[214:0];
      if (expected_recs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected record: %p", got);
      end else begin
        want = expected_recs.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("record mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    #20ms;
    $display("vif_packet_unpack_parser regression: fail");
    $finish;
  end

  initial begin
    parser_clear();
    // mscal with good and bad microcode ids, bytes are imm lo, imm hi, num, cmd
    row(8'd66); row(8'd0); row(8'd0); row_exp(CMD_MSCAL, KIND_CLOSE, ST_OK, 17'd66);
    row(8'hFF); row(8'hFF); row(8'h00); row_exp(CMD_MSCAL, KIND_CLOSE, ST_BAD_MCODE, 17'hFFFF);
    // odd gif count: num 0, so no payload follows
    row(8'h00); row(8'h00); row(8'h00); row_exp(8'h6C, KIND_NOTICE, ST_ODD_GIF, 17'd0);
    // num 0 leaves no payload; signed v4-16
    row(8'h00); row(8'h00); row(8'h00); row_exp(8'h6D, KIND_NOTICE, ST_SIGNED_V4, 17'd0);
    // unknown command, then discarded bytes up to region end
    row(8'h00); row(8'h00); row(8'h00); row_exp(8'h02, KIND_NOTICE, ST_BAD_CMD, 17'd0);
    row(8'hAA); row(8'h55, 1);
    // unknown unpack mode
    row(8'h00); row(8'h00); row(8'h00); row_exp(8'hEB, KIND_NOTICE, ST_BAD_UNPK, 17'd0);
    row(8'h00, 1);
    s_axis_tvalid_i <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // no sender gaps here, so a typed record is swapped in before it can be taken
    send_idle_pct = 0;
    foreach (dir_rows[j]) begin
      send_byte(dir_rows[j].b, dir_rows[j].last);
      if (dir_rows[j].checked) begin
        // typed expectation replaces the predictor's entry for this byte
        void'(expected_recs.pop_back());
        expected_recs.insert(expected_recs.size(), dir_rows[j].rec);
      end
    end
    send_idle_pct = 15;
    // texcoords before any close are skipped; then extremes through texcoord, location, weight
    send_header(7'h65, 8'd1, 16'h0000);
    send_byte(8'hFF, 0); send_byte(8'h7F, 0); send_byte(8'h00, 0); send_byte(8'h80, 0);
    send_header(CMD_MSCAL, 8'd0, 16'd70);
    send_header(7'h65, 8'd1, 16'h0000);
    send_byte(8'hFF, 0); send_byte(8'h7F, 0); send_byte(8'h00, 0); send_byte(8'h80, 0);
    send_header(7'h69, 8'd1, 16'h4000);
    repeat (8) send_byte(8'hFF, 0);
    send_header(7'h6E, 8'd2, 16'h0000);
    send_byte(8'hFC, 0); send_byte(8'h10, 0); send_byte(8'h08, 0); send_byte(8'h10, 0);
    send_byte(8'h04, 0); send_byte(8'h20, 0); send_byte(8'hFF, 0); send_byte(8'h00, 1);
    send_idle_pct = 15; recv_idle_pct = 69;
    while (bytes_total < 1300) begin
      if (bytes_total > 450 && send_idle_pct == 15) begin
        // drain fully once, then swap idling
        s_axis_tvalid_i <= 1'b0;
        wait (expected_recs.size() == 0);
        repeat (4) @(posedge clk_i);
        send_idle_pct = 69; recv_idle_pct = 15;
      end else if (bytes_total > 900 && send_idle_pct == 69) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      random_region();
    end
    s_axis_tvalid_i <= 1'b0;
    s_axis_tlast_i  <= 1'b0;
    wait (expected_recs.size() == 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_recs.size() == 0) begin
      $display("vif_packet_unpack_parser regression: pass");
    end else begin
      $display("vif_packet_unpack_parser regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/vpup_pkg.sv
hdl/vpup_front.sv
hdl/vpup_queue.sv
hdl/vif_packet_unpack_parser.sv
tb/tb_top.sv
